/* hw/rtl/integer_to_ascii_formatter_core_macros.svh */
// Assertion macros for the integer-to-ASCII formatter.
// Used by modules that check their own control; they expect clk_i and rst_ni in scope.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH

// same-cycle implication
`define ITO_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ITO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/ito_pkg.sv */
// Shared types and constants of the integer-to-ASCII formatter.
// No dependencies.
package ito_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned BCD_W   = 40;
  localparam int unsigned DIG_W   = 64;
  localparam int unsigned CNT_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_DEC   = 2'd0,
    OP_HEX   = 2'd1,
    OP_BIN8  = 2'd2,
    OP_BIN16 = 2'd3
  } op_e;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_X     = 7'h78;
  localparam logic [CHAR_W-1:0] CH_ALPHA = 7'h37;  // 'A' - 10

  typedef struct packed {
    logic             load;
    logic [DIG_W-1:0] digits;  // nibbles, most significant at the top
    logic [CNT_W-1:0] count;
    logic             prefix;  // "0x" ahead of the digits
    logic             skip;    // drop leading zeros
  } load_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    if (d < 4'd10) begin
      return CH_ZERO + {3'b000, d};
    end else begin
      return CH_ALPHA + {3'b000, d};
    end
  endfunction

endpackage

/* hw/rtl/ito_if.sv */
// Valid/ready channels of the integer-to-ASCII formatter.
// Depends on ito_pkg.
interface ito_in_if;
  import ito_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [VALUE_W-1:0] value;
  modport source (output valid, op, value, input ready);
  modport sink   (input valid, op, value, output ready);
endinterface

interface ito_out_if;
  import ito_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

/* hw/rtl/ito_dabble.sv */
// Bit-serial binary to BCD conversion (shift and add-3), one bit per cycle.
// Depends on ito_pkg.
module ito_dabble (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [ito_pkg::VALUE_W-1:0]  value_i,
  output logic                         done_o,
  output logic [ito_pkg::BCD_W-1:0]    bcd_o
);
  import ito_pkg::*;

  localparam int unsigned NDIG = BCD_W / 4;

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d, adj;
  logic [4:0]         cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;

  always_comb begin
    logic [3:0] d;
    d = 4'd0;
    for (int i = 0; i < NDIG; i++) begin
      d = bcd_q[4*i +: 4];
      adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = value_i;
      bcd_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      bin_d = {bin_q[VALUE_W-2:0], 1'b0};
      bcd_d = {adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

/* hw/rtl/ito_emit.sv */
// Character emitter: nibble shift register, leading-zero skip, prefix, output register.
// Depends on ito_pkg and ito_if.
module ito_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ito_pkg::load_t  load_i,
  output logic            busy_o,
  ito_out_if.source       out_o
);
  import ito_pkg::*;

  typedef enum logic [4:0] {
    E_IDLE  = 5'b00001,
    E_SKIP  = 5'b00010,
    E_PRE0  = 5'b00100,
    E_PREX  = 5'b01000,
    E_DIGIT = 5'b10000
  } emit_state_e;

  emit_state_e       state_q, state_d;
  logic [DIG_W-1:0]  dig_q, dig_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              pre_q, pre_d;
  logic              vld_q, vld_d;
  logic [CHAR_W-1:0] chr_q, chr_d;
  logic              last_q, last_d;
  logic              adv;

  assign adv = !vld_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    dig_d   = dig_q;
    rem_d   = rem_q;
    pre_d   = pre_q;
    vld_d   = vld_q;
    chr_d   = chr_q;
    last_d  = last_q;
    if (vld_q && out_o.ready) begin
      vld_d = 1'b0;
    end
    case (state_q)
      E_IDLE: begin
        if (load_i.load) begin
          dig_d   = load_i.digits;
          rem_d   = load_i.count;
          pre_d   = load_i.prefix;
          state_d = load_i.skip ? E_SKIP : E_DIGIT;
        end
      end
      E_SKIP: begin
        if (dig_q[DIG_W-1 -: 4] == 4'd0 && rem_q != 5'd1) begin
          dig_d = {dig_q[DIG_W-5:0], 4'd0};
          rem_d = rem_q - 5'd1;
        end else begin
          state_d = pre_q ? E_PRE0 : E_DIGIT;
        end
      end
      E_PRE0: begin
        if (adv) begin
          vld_d   = 1'b1;
          chr_d   = CH_ZERO;
          last_d  = 1'b0;
          state_d = E_PREX;
        end
      end
      E_PREX: begin
        if (adv) begin
          vld_d   = 1'b1;
          chr_d   = CH_X;
          last_d  = 1'b0;
          state_d = E_DIGIT;
        end
      end
      E_DIGIT: begin
        if (adv) begin
          vld_d  = 1'b1;
          chr_d  = digit_char(dig_q[DIG_W-1 -: 4]);
          last_d = (rem_q == 5'd1);
          dig_d  = {dig_q[DIG_W-5:0], 4'd0};
          rem_d  = rem_q - 5'd1;
          if (rem_q == 5'd1) begin
            state_d = E_IDLE;
          end
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q  <= dig_d;
    rem_q  <= rem_d;
    pre_q  <= pre_d;
    chr_q  <= chr_d;
    last_q <= last_d;
  end

  assign busy_o          = (state_q != E_IDLE);
  assign out_o.valid     = vld_q;
  assign out_o.character = chr_q;
  assign out_o.last      = last_q;

endmodule

/* hw/rtl/integer_to_ascii_formatter_core.sv */
// Top level of the integer-to-ASCII formatter: input control, BCD unit, emitter.
// Depends on ito_pkg, ito_if, ito_dabble, ito_emit and the assertion macros.
//
//   channel  dir  payload               transfer
//   in_i     in   op[1:0], value[31:0]  valid && ready
//   out_o    out  character[6:0], last  valid && ready
//
// Decimal: shift-and-add-3 in ito_dabble, then leading-zero skip and 1 to 10
// characters, one per cycle when out_o is not stalled. Hex: leading-zero skip,
// "0x", then 1 to 8 digits. Binary: 8 or 16 characters. One number at a time;
// in_i.ready returns once the last character sits in the output register. Reset
// clears control only; stalls on out_o hold the emitter.
`include "integer_to_ascii_formatter_core_macros.svh"

module integer_to_ascii_formatter_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  ito_in_if.sink    in_i,
  ito_out_if.source out_o
);
  import ito_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CONV = 2'b10
  } ctl_state_e;

  ctl_state_e       state_q, state_d;
  logic             accept;
  logic             conv_start;
  logic             conv_done;
  logic [BCD_W-1:0] bcd;
  logic             emit_busy;
  load_t            load;
  logic [DIG_W-1:0] bin_nib;

  assign in_i.ready = (state_q == S_IDLE) && !emit_busy;
  assign accept     = in_i.valid && in_i.ready;
  assign conv_start = accept && (op_e'(in_i.op) == OP_DEC);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      bin_nib[4*i +: 4] = {3'b000, in_i.value[i]};
    end
  end

  always_comb begin
    load    = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(in_i.op))
            OP_DEC: state_d = S_CONV;
            OP_HEX: begin
              load.load   = 1'b1;
              load.digits = {in_i.value, 32'd0};
              load.count  = 5'd8;
              load.prefix = 1'b1;
              load.skip   = 1'b1;
            end
            OP_BIN8: begin
              load.load   = 1'b1;
              load.digits = {bin_nib[31:0], 32'd0};
              load.count  = 5'd8;
            end
            default: begin
              load.load   = 1'b1;
              load.digits = bin_nib;
              load.count  = 5'd16;
            end
          endcase
        end
      end
      S_CONV: begin
        if (conv_done) begin
          load.load   = 1'b1;
          load.digits = {bcd, 24'd0};
          load.count  = 5'd10;
          load.skip   = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  ito_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .value_i (in_i.value),
    .done_o  (conv_done),
    .bcd_o   (bcd)
  );

  ito_emit u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .busy_o (emit_busy),
    .out_o  (out_o)
  );

  `ITO_ASSERT_IMPL(a_done_in_conv, conv_done, state_q == S_CONV)
  `ITO_ASSERT_IMPL(a_no_load_busy, load.load, !emit_busy)
  `ITO_ASSERT_NEXT(a_accept_busy, accept, state_q == S_CONV || emit_busy)
  `ITO_ASSERT_NEXT(a_conv_to_emit, state_q == S_CONV && conv_done, emit_busy)

endmodule
